// ----- rtl/core/spfl_pkg.sv -----
// Shared constants and field widths for the slot pool free list allocator.
package spfl_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int BLK_W      = 11;
    localparam int SUM_W      = BLK_W + 1;

    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    localparam logic [APB_ADDR_W-1:0] ADDR_BLOCK_SLOTS = 3'd0;

    localparam logic [BLK_W-1:0] BLOCK_SLOTS_RST = 11'd16;
    localparam logic [BLK_W-1:0] BLOCK_SLOTS_MIN = 11'd2;

endpackage

// ----- rtl/core/slot_pool_free_list_allocator.sv -----
// Slot pool allocator: LIFO free list in a link RAM plus a fresh run of the newest block.
//
//  channel | dir | handshake              | word
//  s       | in  | i_s_tvalid/o_s_tready  | tdata: slot_index, slot_is_null; tuser: req_type
//  m       | out | o_m_tvalid/i_m_tready  | tdata: granted_slot, in_use_count, capacity_count;
//          |     |                        | tuser: status
//  apb     | cfg | psel/penable/pready    | block_slots at address 0
//
// Each request first reads the link word at the list head from
// the synchronous link RAM, then updates state and loads the output register.
// The next request is taken while a result waits in the output register; the
// update stalls only if the previous result is still not taken.
// Reset is synchronous; the link RAM is not cleared, entries are used only
// after a free has written them.
module slot_pool_free_list_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [9:0] slot_index, [10] slot_is_null, [15:11] zero
    input  logic [spfl_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [spfl_pkg::REQ_W-1:0]      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [9:0] granted_slot, [20:10] in_use_count, [31:21] capacity_count
    output logic [spfl_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // [1:0] status
    output logic [spfl_pkg::STAT_W-1:0]     o_m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spfl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spfl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spfl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import spfl_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic               r_state;
    logic [BLK_W-1:0]   r_block_slots;

    logic [REQ_W-1:0]   r_req;
    logic [SLOT_W-1:0]  r_idx;
    logic               r_is_null;

    logic [SLOT_W-1:0]  r_head,     n_head;
    logic               r_empty,    n_empty;
    logic [CNT_W-1:0]   r_fresh,    n_fresh;
    logic [CNT_W-1:0]   r_in_use,   n_in_use;
    logic [CNT_W-1:0]   r_capacity, n_capacity;

    logic [SLOT_W-1:0]  r_link_mem [MAX_SLOTS];
    logic [SLOT_W-1:0]  r_link_rd;

    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_granted, n_granted;
    logic [STAT_W-1:0]  r_out_status,  n_status;

    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [SLOT_W-1:0]  mem_wdata;

    logic               in_fire;
    logic               done;
    logic               cfg_wr;
    logic [BLK_W-1:0]   bs;
    logic [SUM_W-1:0]   grow_sum;
    logic               grant_ok;

    assign in_fire    = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign done       = (r_state == ST_EXEC) && (!r_out_valid || i_m_tready);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_BLOCK_SLOTS);
    assign prdata = (paddr == ADDR_BLOCK_SLOTS) ?
                    {{(APB_DATA_W-BLK_W){1'b0}}, r_block_slots} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_slots <= BLOCK_SLOTS_RST;
        end else if (cfg_wr) begin
            r_block_slots <= pwdata[BLK_W-1:0];
        end
    end

    // link RAM: head is read every cycle, stable while a request is in flight
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[mem_waddr] <= mem_wdata;
        end
        r_link_rd <= r_link_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req     <= i_s_tuser;
            r_idx     <= i_s_tdata[SLOT_W-1:0];
            r_is_null <= i_s_tdata[SLOT_W];
        end
    end

    assign bs       = (r_block_slots < BLOCK_SLOTS_MIN) ? BLOCK_SLOTS_MIN : r_block_slots;
    assign grow_sum = {{(SUM_W-CNT_W){1'b0}}, r_capacity} + {{(SUM_W-BLK_W){1'b0}}, bs};

    always_comb begin
        n_head     = r_head;
        n_empty    = r_empty;
        n_fresh    = r_fresh;
        n_in_use   = r_in_use;
        n_capacity = r_capacity;
        n_granted  = '0;
        n_status   = STAT_OK;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = r_empty ? r_idx : r_head;
        grant_ok   = 1'b1;
        case (r_req)
            REQ_ALLOC: begin
                if (!r_empty) begin
                    n_granted = r_head;
                    // bottom entry links to itself
                    if (r_link_rd == r_head) begin
                        n_empty = 1'b1;
                    end else begin
                        n_head = r_link_rd;
                    end
                end else if (r_fresh < r_capacity) begin
                    n_granted = r_fresh[SLOT_W-1:0];
                    n_fresh   = r_fresh + 1'b1;
                end else if (grow_sum <= SUM_W'(MAX_SLOTS)) begin
                    n_granted  = r_capacity[SLOT_W-1:0];
                    n_fresh    = r_capacity + 1'b1;
                    n_capacity = grow_sum[CNT_W-1:0];
                end else begin
                    grant_ok = 1'b0;
                    n_status = STAT_EXHAUSTED;
                end
                if (grant_ok && (r_in_use < CNT_W'(MAX_SLOTS))) begin
                    n_in_use = r_in_use + 1'b1;
                end
            end
            REQ_FREE: begin
                if (!r_is_null) begin
                    if (r_in_use == '0) begin
                        n_status = STAT_UNDERFLOW;
                    end else if ({1'b0, r_idx} < CNT_W'(MAX_SLOTS)) begin
                        mem_we   = done;
                        n_head   = r_idx;
                        n_empty  = 1'b0;
                        n_in_use = r_in_use - 1'b1;
                    end
                end
            end
            REQ_RELEASE: begin
                n_head     = '0;
                n_empty    = 1'b1;
                n_fresh    = '0;
                n_in_use   = '0;
                n_capacity = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_empty    <= 1'b1;
            r_fresh    <= '0;
            r_in_use   <= '0;
            r_capacity <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (done) begin
                        r_state    <= ST_IDLE;
                        r_head     <= n_head;
                        r_empty    <= n_empty;
                        r_fresh    <= n_fresh;
                        r_in_use   <= n_in_use;
                        r_capacity <= n_capacity;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_granted <= n_granted;
            r_out_status  <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_capacity, r_in_use, r_out_granted};
    assign o_m_tuser  = r_out_status;

endmodule

// ----- rtl/core/spfl_checker.sv -----
// Port-level checks for the slot pool allocator, bound to the top level.
module spfl_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [spfl_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [spfl_pkg::STAT_W-1:0]     o_m_tuser,
    input logic                            pready
);
    import spfl_pkg::*;

    logic [SLOT_W-1:0] granted;
    logic [CNT_W-1:0]  in_use_cnt;
    logic [CNT_W-1:0]  cap_cnt;

    assign granted    = o_m_tdata[SLOT_W-1:0];
    assign in_use_cnt = o_m_tdata[SLOT_W+CNT_W-1:SLOT_W];
    assign cap_cnt    = o_m_tdata[SLOT_W+2*CNT_W-1:SLOT_W+CNT_W];

    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != STAT_OK) |-> granted == '0)
        else $error("granted slot nonzero on error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= STAT_UNDERFLOW)
        else $error("status code out of range");

    a_counts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (in_use_cnt <= CNT_W'(MAX_SLOTS)) && (cap_cnt <= CNT_W'(MAX_SLOTS)))
        else $error("counter beyond slot space");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind slot_pool_free_list_allocator spfl_checker u_spfl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);
